// ===== rtl/core/assert_macros.svh =====
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define RPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define RPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/rpt_pkg.sv =====
// -----------------------------------------------------------------------------
// rpt_pkg
// Types, codes and defaults of the ranked-pairs tally engine.
// -----------------------------------------------------------------------------
package rpt_pkg;

  localparam int MAX_CANDIDATES_DEF = 9;
  localparam int TALLY_WIDTH_DEF    = 16;
  localparam int CFG_W              = 4;
  localparam logic [CFG_W-1:0] CFG_MIN = 4'd2;

  // Input commands
  localparam logic CMD_RANK   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // Result kinds
  localparam logic KIND_BAD     = 1'b0;
  localparam logic KIND_OUTCOME = 1'b1;

  typedef struct packed {
    logic       command;
    logic [3:0] candidate_index;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [3:0] winner_index;
    logic [5:0] majority_pairs;
    logic [5:0] locked_pairs;
  } out_item_t;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_TALLY = 14'b00000000000010,
    S_PF_A  = 14'b00000000000100,
    S_PF_B  = 14'b00000000001000,
    S_PF_C  = 14'b00000000010000,
    S_SO_I  = 14'b00000000100000,
    S_SO_IQ = 14'b00000001000000,
    S_SO_J  = 14'b00000010000000,
    S_SO_JQ = 14'b00000100000000,
    S_LK_RD = 14'b00001000000000,
    S_LK_Q  = 14'b00010000000000,
    S_LK_R  = 14'b00100000000000,
    S_WIN   = 14'b01000000000000,
    S_EMIT  = 14'b10000000000000
  } state_t;

endpackage

// ===== rtl/core/rpt_ram.sv =====
// -----------------------------------------------------------------------------
// rpt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// -----------------------------------------------------------------------------
module rpt_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read old contents on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ranked_pairs_tally_engine.sv =====
// -----------------------------------------------------------------------------
// ranked_pairs_tally_engine
// Ranked-pairs election counter built around a tally RAM and a pair RAM.
// -----------------------------------------------------------------------------
// Use:
//   in_*  : one transfer per ballot rank entry (command rank) or per count
//           request (command finish). in_ready is high only while idle.
//   out_* : one result for a bad vote or a finished count; rank entries that
//           are in range give none.
//   cfg_* : candidate count, always ready; write only while idle.
// Sequence:
//   A rank entry at ballot position p > 0 holds in_ready low while the
//   tally RAM does one read-modify-write per earlier rank, pipelined
//   with one-entry forwarding. At position 0 the block stays idle.
//   A bad vote goes straight to the emit state. A finish forms each
//   candidate pair in S_PF_A, S_PF_B and S_PF_C, sorts the pairs, tries
//   each for locking with repeated reach steps, scans for the winner,
//   and passes through the emit state before its result shows.
// Reset: tallies read as zero through per-entry valid flops, locks and
//   ballot position clear at once; no clearing pass is needed.
// Stall: a waiting result sits in the output register; rank entries are
//   still taken, and the next result holds in its state until the
//   register frees.
// -----------------------------------------------------------------------------
module ranked_pairs_tally_engine #(
  parameter int MAX_CANDIDATES = rpt_pkg::MAX_CANDIDATES_DEF,
  parameter int TALLY_WIDTH    = rpt_pkg::TALLY_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  rpt_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rpt_pkg::out_item_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rpt_pkg::CFG_W-1:0] cfg_data
);
  import rpt_pkg::*;
  `include "assert_macros.svh"

  localparam int M      = MAX_CANDIDATES;
  localparam int TW     = TALLY_WIDTH;
  localparam int CW     = $clog2(M);
  localparam int NW     = $clog2(M + 1);
  localparam int TDEPTH = M * M;
  localparam int TAW    = $clog2(TDEPTH);
  localparam int SLOTS  = M * (M - 1) / 2;
  localparam int PAW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PTW    = $clog2(SLOTS + 1);
  localparam int PW     = 2 * CW + TW;
  localparam logic [TW-1:0] TMAX = {TW{1'b1}};

  // Control and state registers
  state_t              state_r, state_nxt;
  logic [CFG_W-1:0]    cfg_r;
  logic [NW-1:0]       pos_r;
  logic [CW-1:0]       order_r [M];
  logic [TDEPTH-1:0]   tvld_r;
  logic                tq_vld_r;
  logic [NW-1:0]       iss_r, lim_r;
  logic [CW-1:0]       idx_r;
  logic                pend_r;
  logic [TAW-1:0]      pend_addr_r;
  logic                fw_v_r;
  logic [TAW-1:0]      fw_addr_r;
  logic [TW-1:0]       fw_data_r;
  logic [CW-1:0]       pi_r, pj_r;
  logic [TW-1:0]       a_r;
  logic [PTW-1:0]      pt_r, si_r, sj_r, lk_cnt_r;
  logic [PW-1:0]       cur_r;
  logic [CW-1:0]       lw_r, ll_r;
  logic [M-1:0]        seen_r;
  logic [M-1:0][M-1:0] lock_r;
  logic [CW-1:0]       wi_r;
  out_item_t           res_r, out_data_r;
  logic                out_valid_r;

  // RAM ports
  logic [TAW-1:0] t_raddr, t_waddr;
  logic           t_we;
  logic [TW-1:0]  t_wdata, t_rdata;
  logic [PAW-1:0] p_raddr, p_waddr;
  logic           p_we;
  logic [PW-1:0]  p_wdata, p_rdata;

  rpt_ram #(.WIDTH(TW), .DEPTH(TDEPTH), .ADDR_W(TAW)) u_tally_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  rpt_ram #(.WIDTH(PW), .DEPTH(SLOTS), .ADDR_W(PAW)) u_pair_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  // Live candidate count, clamped to the supported range
  logic [NW-1:0] n_w;
  always_comb begin
    if (cfg_r < CFG_MIN) begin
      n_w = NW'(CFG_MIN);
    end else if ({1'b0, cfg_r} > 5'(M)) begin
      n_w = NW'(M);
    end else begin
      n_w = NW'(cfg_r);
    end
  end

  // Handshakes
  logic in_fire, bad_idx;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign bad_idx   = {1'b0, in_data.candidate_index} >= 5'(n_w);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Ballot position bookkeeping
  logic [NW-1:0] p0, p1;
  assign p0 = (pos_r >= n_w) ? '0 : pos_r;
  assign p1 = p0 + NW'(1);

  // Tally addresses
  logic [TAW-1:0] tal_addr, addr_ij, addr_ji;
  assign tal_addr = TAW'(order_r[iss_r[CW-1:0]]) * TAW'(M) + TAW'(idx_r);
  assign addr_ij  = TAW'(pi_r) * TAW'(M) + TAW'(pj_r);
  assign addr_ji  = TAW'(pj_r) * TAW'(M) + TAW'(pi_r);

  // Tally read data, reset entries read zero, last write forwarded
  logic [TW-1:0] t_eff, t_cur;
  logic          issuing;
  assign t_eff   = tq_vld_r ? t_rdata : '0;
  assign t_cur   = (fw_v_r && fw_addr_r == pend_addr_r) ? fw_data_r : t_eff;
  assign issuing = (iss_r < lim_r);

  // New pair from the two opposing tallies
  logic [PW-1:0] pf_pair;
  logic          a_wins;
  assign a_wins  = a_r > t_eff;
  assign pf_pair = a_wins ? {pi_r, pj_r, a_r - t_eff} : {pj_r, pi_r, t_eff - a_r};

  // Sort compare
  logic sort_swap;
  assign sort_swap = cur_r[TW-1:0] < p_rdata[TW-1:0];

  // One reach step over the locked graph
  logic [M-1:0] reach;
  always_comb begin
    reach = seen_r;
    for (int v = 0; v < M; v++) begin
      if (seen_r[v]) begin
        reach = reach | lock_r[v];
      end
    end
  end

  // Column of the winner candidate
  logic beaten;
  always_comb begin
    beaten = 1'b0;
    for (int j = 0; j < M; j++) begin
      beaten = beaten | lock_r[j][wi_r];
    end
  end

  // RAM control
  always_comb begin
    t_raddr = '0;
    t_we    = 1'b0;
    t_waddr = pend_addr_r;
    t_wdata = (t_cur == TMAX) ? t_cur : t_cur + TW'(1);
    p_raddr = '0;
    p_we    = 1'b0;
    p_waddr = PAW'(pt_r);
    p_wdata = pf_pair;
    case (state_r)
      S_TALLY: begin
        t_raddr = tal_addr;
        t_we    = pend_r;
      end
      S_PF_A: t_raddr = addr_ij;
      S_PF_B: t_raddr = addr_ji;
      S_PF_C: p_we = (a_r != t_eff);
      S_SO_I: p_raddr = PAW'(si_r);
      S_SO_J: begin
        if (sj_r >= pt_r) begin
          p_we    = 1'b1;
          p_waddr = PAW'(si_r);
          p_wdata = cur_r;
        end else begin
          p_raddr = PAW'(sj_r);
        end
      end
      S_SO_JQ: begin
        p_we    = sort_swap;
        p_waddr = PAW'(sj_r);
        p_wdata = cur_r;
      end
      S_LK_RD: p_raddr = PAW'(si_r);
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.command == CMD_FINISH) begin
            state_nxt = S_PF_A;
          end else if (bad_idx) begin
            state_nxt = S_EMIT;
          end else if (p0 != '0) begin
            state_nxt = S_TALLY;
          end
        end
      end
      S_TALLY: if (!issuing) state_nxt = S_IDLE;
      S_PF_A:  state_nxt = S_PF_B;
      S_PF_B:  state_nxt = S_PF_C;
      S_PF_C: begin
        if (NW'(pj_r) + NW'(1) < n_w || NW'(pi_r) + NW'(2) < n_w) begin
          state_nxt = S_PF_A;
        end else begin
          state_nxt = S_SO_I;
        end
      end
      S_SO_I:  state_nxt = (si_r >= pt_r) ? S_LK_RD : S_SO_IQ;
      S_SO_IQ: state_nxt = S_SO_J;
      S_SO_J:  state_nxt = (sj_r >= pt_r) ? S_SO_I : S_SO_JQ;
      S_SO_JQ: state_nxt = S_SO_J;
      S_LK_RD: state_nxt = (si_r >= pt_r) ? S_WIN : S_LK_Q;
      S_LK_Q:  state_nxt = S_LK_R;
      S_LK_R:  if (reach == seen_r) state_nxt = S_LK_RD;
      S_WIN:   if (!beaten) state_nxt = S_EMIT;
      S_EMIT:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= CFG_MIN;
      pos_r       <= '0;
      tvld_r      <= '0;
      lock_r      <= '0;
      pt_r        <= '0;
      fw_v_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fw_v_r  <= t_we;
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
      if (t_we) begin
        tvld_r[t_waddr] <= 1'b1;
      end
      pend_r <= (state_r == S_TALLY) && issuing;
      // Accepted item
      if (in_fire) begin
        if (in_data.command == CMD_FINISH) begin
          pos_r  <= '0;
          lock_r <= '0;
          pt_r   <= '0;
        end else if (!bad_idx) begin
          pos_r <= (p1 >= n_w) ? '0 : p1;
        end
      end
      if (p_we && state_r == S_PF_C) begin
        pt_r <= pt_r + PTW'(1);
      end
      if (state_r == S_LK_R && reach == seen_r && !seen_r[lw_r]) begin
        lock_r[lw_r][ll_r] <= 1'b1;
      end
      // Output register
      if (state_r == S_EMIT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    tq_vld_r    <= tvld_r[t_raddr];
    fw_addr_r   <= t_waddr;
    fw_data_r   <= t_wdata;
    pend_addr_r <= tal_addr;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.command == CMD_FINISH) begin
            pi_r     <= '0;
            pj_r     <= CW'(1);
            lk_cnt_r <= '0;
          end else if (bad_idx) begin
            res_r <= '{result_kind: KIND_BAD, winner_index: 4'd0,
                       majority_pairs: 6'd0, locked_pairs: 6'd0};
          end else begin
            order_r[p0[CW-1:0]] <= in_data.candidate_index[CW-1:0];
            idx_r <= in_data.candidate_index[CW-1:0];
            iss_r <= '0;
            lim_r <= p0;
          end
        end
      end
      S_TALLY: if (issuing) iss_r <= iss_r + NW'(1);
      S_PF_B:  a_r <= t_eff;
      S_PF_C: begin
        if (NW'(pj_r) + NW'(1) < n_w) begin
          pj_r <= pj_r + CW'(1);
        end else begin
          pi_r <= pi_r + CW'(1);
          pj_r <= CW'(NW'(pi_r) + NW'(2));
        end
        si_r <= '0;
      end
      S_SO_I:  if (si_r >= pt_r) si_r <= '0;
      S_SO_IQ: begin
        cur_r <= p_rdata;
        sj_r  <= si_r + PTW'(1);
      end
      S_SO_J:  if (sj_r >= pt_r) si_r <= si_r + PTW'(1);
      S_SO_JQ: begin
        if (sort_swap) begin
          cur_r <= p_rdata;
        end
        sj_r <= sj_r + PTW'(1);
      end
      S_LK_RD: wi_r <= '0;
      S_LK_Q: begin
        lw_r   <= p_rdata[PW-1 -: CW];
        ll_r   <= p_rdata[PW-CW-1 -: CW];
        seen_r <= {{(M-1){1'b0}}, 1'b1} << p_rdata[PW-CW-1 -: CW];
      end
      S_LK_R: begin
        if (reach == seen_r) begin
          if (!seen_r[lw_r]) begin
            lk_cnt_r <= lk_cnt_r + PTW'(1);
          end
          si_r <= si_r + PTW'(1);
        end else begin
          seen_r <= reach;
        end
      end
      S_WIN: begin
        if (!beaten) begin
          res_r <= '{result_kind: KIND_OUTCOME, winner_index: 4'(wi_r),
                     majority_pairs: 6'(pt_r), locked_pairs: 6'(lk_cnt_r)};
        end else begin
          wi_r <= wi_r + CW'(1);
        end
      end
      S_EMIT: if (!out_valid_r || out_ready) out_data_r <= res_r;
      default: ;
    endcase
  end

  // Assertions
  `RPT_ASSERT(a_lock_le_pairs, (state_r == S_WIN) |-> (lk_cnt_r <= pt_r),
    "more pairs locked than formed")
  `RPT_ASSERT(a_tally_wr_state, t_we |-> (state_r == S_TALLY),
    "tally RAM written outside a rank update")
  `RPT_ASSERT(a_out_from_emit, $rose(out_valid_r) |-> $past(state_r == S_EMIT),
    "result presented without passing the emit state")
  `RPT_ASSERT_ALWAYS(a_reset_idle, $past(!rst_n) |-> (state_r == S_IDLE && !out_valid_r),
    "block not idle after reset")

endmodule
